>>> rtl/cgq_pkg.sv
// ----------------------------------------------------------------------------
// cgq_pkg
// Types, sizes and helper functions shared by the code group quantizer.
// ----------------------------------------------------------------------------
package cgq_pkg;

    localparam int GROUP_SIZE = 4;
    localparam int COEF_W     = 32;
    localparam int QMAG_W     = 31;
    localparam int BPC_W      = 5;
    localparam int CNT_W      = 3;
    localparam int CW_W       = 3;
    // a bit length of a 32 bit magnitude goes up to 32
    localparam int BLEN_W     = 6;
    localparam int SHIFT_W    = 6;
    localparam int WIDE_W     = 64;

    localparam logic [CW_W-1:0]  CW_MIN = 3'd1;
    localparam logic [CW_W-1:0]  CW_MAX = 3'd5;
    localparam logic [CW_W-1:0]  CW_RESET = 3'd4;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(GROUP_SIZE);

    // register indexes on the configuration port, byte address is index * 4
    localparam logic REG_UNIFORM_MODE = 1'b0;
    localparam logic REG_COUNT_WIDTH  = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_0;
        logic signed [COEF_W-1:0] coef_1;
        logic signed [COEF_W-1:0] coef_2;
        logic signed [COEF_W-1:0] coef_3;
        logic [CNT_W-1:0]         valid_count;
        logic [BPC_W-1:0]         truncation;
    } t_in_item;

    typedef struct packed {
        logic [BPC_W-1:0]  bitplane_count;
        logic [QMAG_W-1:0] qmag_0;
        logic [QMAG_W-1:0] qmag_1;
        logic [QMAG_W-1:0] qmag_2;
        logic [QMAG_W-1:0] qmag_3;
        logic              neg_0;
        logic              neg_1;
        logic              neg_2;
        logic              neg_3;
        logic              overflow;
    } t_out_item;

    // position of the highest set bit plus one, zero for zero
    function automatic logic [BLEN_W-1:0] bit_length(input logic [COEF_W-1:0] v);
        logic [BLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < COEF_W; i++) begin
            if (v[i]) begin
                n = BLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/code_group_quantizer.sv
// ----------------------------------------------------------------------------
// code_group_quantizer
// Bitplane count and deadzone or uniform quantization of one code group.
// ----------------------------------------------------------------------------
// an input transfer passes the input register, the count stage register and
//   the result register before its result is valid
// throughput: one code group per cycle while the output is not stalled; a full
//   pipeline takes a new item in the cycle its oldest result transfers out
// reset: synchronous active low, clears the stage valids and sets
//   uniform_mode to 0 and count_width to 4
module code_group_quantizer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cgq_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cgq_pkg::t_out_item    o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import cgq_pkg::*;

    // configuration registers
    logic            r_uniform_mode;
    logic [CW_W-1:0] r_count_width;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform_mode <= 1'b0;
            r_count_width  <= CW_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_UNIFORM_MODE: r_uniform_mode <= pwdata[0];
                REG_COUNT_WIDTH:  r_count_width  <= pwdata[CW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_UNIFORM_MODE: prdata = {31'd0, r_uniform_mode};
            REG_COUNT_WIDTH:  prdata = {29'd0, r_count_width};
            default:          prdata = '0;
        endcase
    end

    // stage ready chain
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready   = !r_out_valid || i_out_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;

    // stage 1: input register
    t_in_item r_s1_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    // stage 1 -> 2: magnitudes, raw count, overflow
    logic [COEF_W-1:0] coef   [GROUP_SIZE];
    logic [COEF_W-1:0] mag    [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] sign_s1;
    logic [CNT_W-1:0]  nvalid;
    logic [COEF_W-1:0] mag_or;
    logic [BLEN_W-1:0] mraw;
    logic [CW_W-1:0]   cw;
    logic [BLEN_W-1:0] max_m;
    logic              ov_s1;
    logic [BPC_W-1:0]  m_s1;
    logic [SHIFT_W-1:0] zeta_s1;

    assign coef[0] = r_s1_data.coef_0;
    assign coef[1] = r_s1_data.coef_1;
    assign coef[2] = r_s1_data.coef_2;
    assign coef[3] = r_s1_data.coef_3;

    always_comb begin
        nvalid = (r_s1_data.valid_count > CNT_MAX) ? CNT_MAX : r_s1_data.valid_count;
        mag_or = '0;
        for (int k = 0; k < GROUP_SIZE; k++) begin
            // padding entries are dropped here so they quantize to zero
            if (CNT_W'(k) < nvalid) begin
                mag[k]     = coef[k][COEF_W-1] ? (~coef[k] + 1'b1) : coef[k];
                sign_s1[k] = coef[k][COEF_W-1];
            end else begin
                mag[k]     = '0;
                sign_s1[k] = 1'b0;
            end
            mag_or = mag_or | mag[k];
        end
        // bit length of the largest equals bit length of the or of all
        mraw = bit_length(mag_or);
        if (r_count_width < CW_MIN) begin
            cw = CW_MIN;
        end else if (r_count_width > CW_MAX) begin
            cw = CW_MAX;
        end else begin
            cw = r_count_width;
        end
        max_m = (BLEN_W'(1) << cw) - 1'b1;
        ov_s1 = mraw > max_m;
        m_s1  = (mraw[BPC_W-1:0] > r_s1_data.truncation) ? mraw[BPC_W-1:0]
                                                         : r_s1_data.truncation;
        zeta_s1 = SHIFT_W'(m_s1) - SHIFT_W'(r_s1_data.truncation) + 1'b1;
    end

    // stage 2 register
    logic [QMAG_W-1:0]     r_s2_mag [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] r_s2_sign;
    logic [BPC_W-1:0]      r_s2_m;
    logic [BPC_W-1:0]      r_s2_t;
    logic [SHIFT_W-1:0]    r_s2_zeta;
    logic                  r_s2_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            for (int k = 0; k < GROUP_SIZE; k++) begin
                // without overflow every magnitude fits 31 bits
                r_s2_mag[k] <= mag[k][QMAG_W-1:0];
            end
            r_s2_sign <= sign_s1;
            r_s2_m    <= m_s1;
            r_s2_t    <= r_s1_data.truncation;
            r_s2_zeta <= zeta_s1;
            r_s2_ov   <= ov_s1;
        end
    end

    // stage 2 -> 3: quantizer lanes
    logic [QMAG_W-1:0]     q   [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] neg;
    logic [WIDE_W-1:0]     wmag;
    logic [WIDE_W-1:0]     wsum;
    logic [WIDE_W-1:0]     wq;
    logic [SHIFT_W-1:0]    m_plus1;

    always_comb begin
        wmag    = '0;
        wsum    = '0;
        wq      = '0;
        m_plus1 = SHIFT_W'(r_s2_m) + 1'b1;
        for (int k = 0; k < GROUP_SIZE; k++) begin
            wmag = WIDE_W'(r_s2_mag[k]);
            if (r_s2_ov) begin
                q[k] = '0;
            end else if (!r_uniform_mode) begin
                q[k] = r_s2_mag[k] >> r_s2_t;
            end else if (r_s2_m <= r_s2_t) begin
                q[k] = '0;
            end else begin
                // mag * (2^zeta - 1) plus half a step, then down by m + 1
                wsum = (wmag << r_s2_zeta) - wmag + (WIDE_W'(1) << r_s2_m);
                wq   = wsum >> m_plus1;
                q[k] = wq[QMAG_W-1:0];
            end
            neg[k] = r_s2_sign[k] && (q[k] != '0);
        end
    end

    // result register
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_out_data.bitplane_count <= r_s2_ov ? '0 : r_s2_m;
            r_out_data.qmag_0         <= q[0];
            r_out_data.qmag_1         <= q[1];
            r_out_data.qmag_2         <= q[2];
            r_out_data.qmag_3         <= q[3];
            r_out_data.neg_0          <= neg[0];
            r_out_data.neg_1          <= neg[1];
            r_out_data.neg_2          <= neg[2];
            r_out_data.neg_3          <= neg[3];
            r_out_data.overflow       <= r_s2_ov;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an overflowed transfer carries no count and no magnitudes
    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (o_out_data.bitplane_count == '0 && o_out_data.qmag_0 == '0 &&
             o_out_data.qmag_1 == '0 && o_out_data.qmag_2 == '0 &&
             o_out_data.qmag_3 == '0))
        else $error("overflow result carries nonzero fields");

    // a sign flag only stands with a nonzero magnitude
    a_neg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((!o_out_data.neg_0 || o_out_data.qmag_0 != '0) &&
             (!o_out_data.neg_1 || o_out_data.qmag_1 != '0) &&
             (!o_out_data.neg_2 || o_out_data.qmag_2 != '0) &&
             (!o_out_data.neg_3 || o_out_data.qmag_3 != '0)))
        else $error("sign set on zero magnitude");

    // an empty pipeline never stalls the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_s2_valid && !r_out_valid) |-> o_in_ready)
        else $error("input stalled with empty pipeline");

    // a stage holding an item with the next stage blocked keeps it
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_ready) |=> (r_s2_valid && $stable(r_s2_m)))
        else $error("stage two item lost under stall");

endmodule
